[rtl/core/cwbm_pkg.sv]
package cwbm_pkg;

	localparam int DATA_W  = 32;
	localparam int CHAN_W  = 8;
	localparam int COUNT_W = 8;
	localparam int CODE_W  = 3;
	localparam int ADDR_W  = 5;
	localparam int LANES   = 3;

	typedef enum logic [CODE_W-1:0] {
		EV_SAMPLE_CRIT = 3'd0,
		EV_NEAR_CRIT   = 3'd1,
		EV_FAR_CRIT    = 3'd2,
		EV_CONFIRMED   = 3'd3,
		EV_ENTER_WARN  = 3'd4
	} event_code_t;

	typedef enum logic [2:0] {
		REG_CRITICAL_ENABLED = 3'd0,
		REG_CRITICAL_LOW     = 3'd1,
		REG_CRITICAL_HIGH    = 3'd2,
		REG_CONFIRM_LIMIT    = 3'd3,
		REG_WARNING_LOW      = 3'd4,
		REG_WARNING_HIGH     = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic                      critical_enabled;
		logic signed [DATA_W-1:0]  critical_low;
		logic signed [DATA_W-1:0]  critical_high;
		logic [COUNT_W-1:0]        confirm_limit;
		logic signed [DATA_W-1:0]  warning_low;
		logic signed [DATA_W-1:0]  warning_high;
	} cfg_t;

	typedef struct packed {
		logic [LANES-1:0]  crit;
		logic              warn_out;
		logic              too_high;
		logic [CHAN_W-1:0] channel;
	} lane_flags_t;

endpackage

[rtl/core/critical_warning_bound_monitor_top.sv]
// Critical and warning bound monitor.
// Input channel (item_valid/item_ready): sample, near_projection, far_projection and
// channel. Three comparator lanes test the three values against the critical limits
// and a fourth tests the sample against the warning limits; a merge stage picks the
// first critical value, updates the persistence count and warning flag, and builds
// the event.
// Output channel (event_valid/event_ready): event_code, too_high, channel_out. A
// transaction yields zero or one event.
// An event passes the lane register and then the merge stage's output register.
// Throughput: one transaction per cycle while no held event stalls the merge stage,
// which updates the count and warning flag for each transaction.
// Configuration: APB port, register i at byte address 4*i, pready always high; write
// registers only while no transaction is in flight.
// Reset: persistence count and warning flag clear, critical checking is off and all
// limits open to the full signed range.
// Stall: a held event blocks the merge stage; one more transaction is held in the lane
// register, after which item_ready drops.
module critical_warning_bound_monitor_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cwbm_pkg::ADDR_W-1:0]   paddr,
	input  logic [cwbm_pkg::DATA_W-1:0]   pwdata,
	output logic [cwbm_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic signed [cwbm_pkg::DATA_W-1:0] sample,
	input  logic signed [cwbm_pkg::DATA_W-1:0] near_projection,
	input  logic signed [cwbm_pkg::DATA_W-1:0] far_projection,
	input  logic [cwbm_pkg::CHAN_W-1:0]   channel,
	output logic                          event_valid,
	input  logic                          event_ready,
	output logic [cwbm_pkg::CODE_W-1:0]   event_code,
	output logic                          too_high,
	output logic [cwbm_pkg::CHAN_W-1:0]   channel_out
);
	import cwbm_pkg::*;

	cfg_t                     cfg;
	logic signed [DATA_W-1:0] vals [LANES];
	logic [LANES-1:0]         crit;
	logic [LANES-1:0]         crit_below;
	logic [LANES-1:0]         crit_above;
	logic                     warn_below;
	logic                     warn_above;
	logic                     warn_out;
	logic                     valid_s1;
	lane_flags_t              flags_s1;
	logic                     take;
	logic                     item_acc;

	assign vals[0] = sample;
	assign vals[1] = near_projection;
	assign vals[2] = far_projection;

	cwbm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		cwbm_lane u_lane (
			.value   (vals[g]),
			.low     (cfg.critical_low),
			.high    (cfg.critical_high),
			.below   (crit_below[g]),
			.above   (crit_above[g]),
			.outside (crit[g])
		);
	end

	cwbm_lane u_warn_lane (
		.value   (sample),
		.low     (cfg.warning_low),
		.high    (cfg.warning_high),
		.below   (warn_below),
		.above   (warn_above),
		.outside (warn_out)
	);

	assign item_ready = ~valid_s1 | take;
	assign item_acc   = item_valid & item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_acc) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			flags_s1.crit     <= crit;
			flags_s1.warn_out <= warn_below | warn_above;
			flags_s1.too_high <= warn_above;
			flags_s1.channel  <= channel;
		end
	end

	cwbm_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.flags_valid (valid_s1),
		.flags       (flags_s1),
		.cfg         (cfg),
		.take        (take),
		.event_valid (event_valid),
		.event_ready (event_ready),
		.event_code  (event_code),
		.too_high    (too_high),
		.channel_out (channel_out)
	);

	a_lane_agree: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc |-> warn_out == (warn_below | warn_above)
			&& crit == (crit_below | crit_above))
		else $error("lane outputs disagree");

endmodule

[rtl/core/cwbm_lane.sv]
module cwbm_lane (
	input  logic signed [cwbm_pkg::DATA_W-1:0] value,
	input  logic signed [cwbm_pkg::DATA_W-1:0] low,
	input  logic signed [cwbm_pkg::DATA_W-1:0] high,
	output logic                               below,
	output logic                               above,
	output logic                               outside
);
	import cwbm_pkg::*;

	assign below   = value < low;
	assign above   = value > high;
	assign outside = below | above;

endmodule

[rtl/core/cwbm_cfg.sv]
module cwbm_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cwbm_pkg::ADDR_W-1:0]   paddr,
	input  logic [cwbm_pkg::DATA_W-1:0]   pwdata,
	output logic [cwbm_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output cwbm_pkg::cfg_t                cfg
);
	import cwbm_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	reg_index_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = reg_index_t'(paddr[ADDR_W-1:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.critical_enabled <= 1'b0;
			cfg_q.critical_low     <= {1'b1, {(DATA_W-1){1'b0}}};
			cfg_q.critical_high    <= {1'b0, {(DATA_W-1){1'b1}}};
			cfg_q.confirm_limit    <= '0;
			cfg_q.warning_low      <= {1'b1, {(DATA_W-1){1'b0}}};
			cfg_q.warning_high     <= {1'b0, {(DATA_W-1){1'b1}}};
		end else if (wr_en) begin
			unique case (idx)
				REG_CRITICAL_ENABLED: cfg_q.critical_enabled <= pwdata[0];
				REG_CRITICAL_LOW:     cfg_q.critical_low     <= pwdata;
				REG_CRITICAL_HIGH:    cfg_q.critical_high    <= pwdata;
				REG_CONFIRM_LIMIT:    cfg_q.confirm_limit    <= pwdata[COUNT_W-1:0];
				REG_WARNING_LOW:      cfg_q.warning_low      <= pwdata;
				REG_WARNING_HIGH:     cfg_q.warning_high     <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CRITICAL_ENABLED: prdata = {{(DATA_W-1){1'b0}}, cfg_q.critical_enabled};
			REG_CRITICAL_LOW:     prdata = cfg_q.critical_low;
			REG_CRITICAL_HIGH:    prdata = cfg_q.critical_high;
			REG_CONFIRM_LIMIT:    prdata = {{(DATA_W-COUNT_W){1'b0}}, cfg_q.confirm_limit};
			REG_WARNING_LOW:      prdata = cfg_q.warning_low;
			REG_WARNING_HIGH:     prdata = cfg_q.warning_high;
			default:              prdata = '0;
		endcase
	end

endmodule

[rtl/core/cwbm_merge.sv]
module cwbm_merge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          flags_valid,
	input  cwbm_pkg::lane_flags_t         flags,
	input  cwbm_pkg::cfg_t                cfg,
	output logic                          take,
	output logic                          event_valid,
	input  logic                          event_ready,
	output logic [cwbm_pkg::CODE_W-1:0]   event_code,
	output logic                          too_high,
	output logic [cwbm_pkg::CHAN_W-1:0]   channel_out
);
	import cwbm_pkg::*;

	logic [COUNT_W-1:0] persist_count_q;
	logic               in_warning_q;
	logic               valid_q;
	event_code_t        code_q;
	logic               too_high_q;
	logic [CHAN_W-1:0]  channel_q;

	logic               crit_hit;
	logic [COUNT_W-1:0] count_inc;
	logic [COUNT_W-1:0] count_nxt;
	logic               warn_nxt;
	logic               emit;
	event_code_t        code_nxt;

	assign take     = flags_valid & (~valid_q | event_ready);
	assign crit_hit = cfg.critical_enabled & (|flags.crit);
	assign count_inc = (persist_count_q == {COUNT_W{1'b1}}) ? persist_count_q
		: persist_count_q + COUNT_W'(1);

	always_comb begin
		count_nxt = persist_count_q;
		warn_nxt  = in_warning_q;
		emit      = 1'b0;
		code_nxt  = EV_ENTER_WARN;
		if (crit_hit) begin
			count_nxt = count_inc;
			emit      = 1'b1;
			priority if (flags.crit[0]) code_nxt = EV_SAMPLE_CRIT;
			else if (flags.crit[1])     code_nxt = EV_NEAR_CRIT;
			else                        code_nxt = EV_FAR_CRIT;
			if (cfg.confirm_limit != '0 && count_inc > cfg.confirm_limit)
				code_nxt = EV_CONFIRMED;
		end else begin
			if (cfg.critical_enabled && persist_count_q != '0)
				count_nxt = persist_count_q - COUNT_W'(1);
			if (flags.warn_out) begin
				warn_nxt = 1'b1;
				emit     = ~in_warning_q;
			end else begin
				warn_nxt = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			persist_count_q <= '0;
			in_warning_q    <= 1'b0;
			valid_q         <= 1'b0;
		end else if (take) begin
			persist_count_q <= count_nxt;
			in_warning_q    <= warn_nxt;
			valid_q         <= emit;
		end else if (event_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			code_q     <= code_nxt;
			too_high_q <= flags.too_high;
			channel_q  <= flags.channel;
		end
	end

	assign event_valid = valid_q;
	assign event_code  = code_q;
	assign too_high    = too_high_q;
	assign channel_out = channel_q;

	a_count_hold_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		take && !cfg.critical_enabled |=> $stable(persist_count_q))
		else $error("persistence count moved while critical checking was off");

	a_count_step_up: assert property (@(posedge clk) disable iff (!arst_n)
		take && crit_hit && persist_count_q != {COUNT_W{1'b1}}
		|=> persist_count_q == $past(persist_count_q) + COUNT_W'(1))
		else $error("persistence count did not advance on a critical transaction");

	a_warn_entry: assert property (@(posedge clk) disable iff (!arst_n)
		take && !crit_hit && flags.warn_out && !in_warning_q
		|=> valid_q && code_q == EV_ENTER_WARN && in_warning_q)
		else $error("warning entry did not produce a warning event");

	a_confirm_needs_limit: assert property (@(posedge clk) disable iff (!arst_n)
		take && emit && code_nxt == EV_CONFIRMED |-> cfg.confirm_limit != '0)
		else $error("confirmed event with confirmation disabled");

endmodule

[verif/bound_event_checker.sv]
`timescale 1ns / 100ps
module bound_event_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cwbm_pkg::ADDR_W-1:0]       paddr,
	input  logic [cwbm_pkg::DATA_W-1:0]       pwdata,
	input  logic                              pready,
	input  logic                              item_valid,
	input  logic                              item_ready,
	input  logic signed [cwbm_pkg::DATA_W-1:0] sample,
	input  logic signed [cwbm_pkg::DATA_W-1:0] near_projection,
	input  logic signed [cwbm_pkg::DATA_W-1:0] far_projection,
	input  logic [cwbm_pkg::CHAN_W-1:0]       channel,
	input  logic                              event_valid,
	input  logic                              event_ready,
	input  logic [cwbm_pkg::CODE_W-1:0]       event_code,
	input  logic                              too_high,
	input  logic [cwbm_pkg::CHAN_W-1:0]       channel_out,
	output int                                mismatches,
	output int                                pending
);
	import cwbm_pkg::*;

	typedef struct {
		event_code_t       code;
		logic              too_high;
		logic [CHAN_W-1:0] chan;
	} alarm_t;

	logic                     crit_en;
	logic signed [DATA_W-1:0] crit_lo;
	logic signed [DATA_W-1:0] crit_hi;
	logic [COUNT_W-1:0]       confirm_at;
	logic signed [DATA_W-1:0] warn_lo;
	logic signed [DATA_W-1:0] warn_hi;
	logic [COUNT_W-1:0]       crit_run;
	logic                     warn_active;
	alarm_t                   expected_alarms[$];

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	function automatic bit predict_alarm(
		input  logic signed [DATA_W-1:0] s,
		input  logic signed [DATA_W-1:0] n,
		input  logic signed [DATA_W-1:0] f,
		input  logic [CHAN_W-1:0]        ch,
		output alarm_t                   a
	);
		logic signed [DATA_W-1:0] lane_val [LANES];
		lane_val[0] = s;
		lane_val[1] = n;
		lane_val[2] = f;
		a.too_high = (s > warn_hi);
		a.chan = ch;
		a.code = EV_ENTER_WARN;
		if (crit_en) begin
			for (int k = 0; k < LANES; k++) begin
				if (lane_val[k] < crit_lo || lane_val[k] > crit_hi) begin
					if (crit_run != '1)
						crit_run++;
					if (confirm_at != '0 && crit_run > confirm_at)
						a.code = EV_CONFIRMED;
					else if (k == 0)
						a.code = EV_SAMPLE_CRIT;
					else if (k == 1)
						a.code = EV_NEAR_CRIT;
					else
						a.code = EV_FAR_CRIT;
					return 1'b1;
				end
			end
			if (crit_run != '0)
				crit_run--;
		end
		if (s < warn_lo || s > warn_hi) begin
			if (!warn_active) begin
				warn_active = 1'b1;
				return 1'b1;
			end
		end else begin
			warn_active = 1'b0;
		end
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		alarm_t want;
		alarm_t fresh;
		if (!arst_n) begin
			crit_en = 1'b0;
			crit_lo = 32'sh8000_0000;
			crit_hi = 32'sh7fff_ffff;
			confirm_at = '0;
			warn_lo = 32'sh8000_0000;
			warn_hi = 32'sh7fff_ffff;
			crit_run = '0;
			warn_active = 1'b0;
			expected_alarms.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_index_t'(paddr[ADDR_W-1:2]))
					REG_CRITICAL_ENABLED: crit_en = pwdata[0];
					REG_CRITICAL_LOW:     crit_lo = pwdata;
					REG_CRITICAL_HIGH:    crit_hi = pwdata;
					REG_CONFIRM_LIMIT:    confirm_at = pwdata[COUNT_W-1:0];
					REG_WARNING_LOW:      warn_lo = pwdata;
					REG_WARNING_HIGH:     warn_hi = pwdata;
					default: ;
				endcase
			end
			if (event_valid && event_ready) begin
				if (expected_alarms.size() == 0) begin
					report_mismatch($sformatf("unexpected event code %0d channel %0d",
						event_code, channel_out));
				end else begin
					want = expected_alarms.pop_front();
					if (event_code !== want.code)
						report_mismatch($sformatf("event_code %0d, expected %0d",
							event_code, want.code));
					if (too_high !== want.too_high)
						report_mismatch($sformatf("too_high %0b, expected %0b",
							too_high, want.too_high));
					if (channel_out !== want.chan)
						report_mismatch($sformatf("channel_out %0d, expected %0d",
							channel_out, want.chan));
				end
			end
			if (item_valid && item_ready) begin
				if (predict_alarm(sample, near_projection, far_projection, channel, fresh))
					expected_alarms.push_back(fresh);
			end
			pending <= expected_alarms.size();
		end
	end

endmodule

[verif/tb_critical_warning_bound_monitor_top.sv]
`timescale 1ns / 100ps
module tb_critical_warning_bound_monitor_top;
	import cwbm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;

	typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC, RX_BLOCKED} rx_mode_t;
	typedef enum int {
		PROF_DISABLED, PROF_NESTED, PROF_SATURATE, PROF_OPEN, PROF_POINT, PROF_WILD
	} limit_profile_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [ADDR_W-1:0]        paddr = '0;
	logic [DATA_W-1:0]        pwdata = '0;
	logic [DATA_W-1:0]        prdata;
	logic                     pready;
	logic                     item_valid = 1'b0;
	logic                     item_ready;
	logic signed [DATA_W-1:0] sample = '0;
	logic signed [DATA_W-1:0] near_projection = '0;
	logic signed [DATA_W-1:0] far_projection = '0;
	logic [CHAN_W-1:0]        channel = '0;
	logic                     event_valid;
	logic                     event_ready = 1'b0;
	logic [CODE_W-1:0]        event_code;
	logic                     too_high;
	logic [CHAN_W-1:0]        channel_out;

	int       mismatches;
	int       pending;
	int       cycle_count = 0;
	int       burst_left = 0;
	int       stall_left = 0;
	rx_mode_t stall_mode = RX_OPEN;

	logic signed [DATA_W-1:0] cur_clo;
	logic signed [DATA_W-1:0] cur_chi;
	logic [COUNT_W-1:0]       cur_conf;
	logic signed [DATA_W-1:0] cur_wlo;
	logic signed [DATA_W-1:0] cur_whi;

	critical_warning_bound_monitor_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.item_valid      (item_valid),
		.item_ready      (item_ready),
		.sample          (sample),
		.near_projection (near_projection),
		.far_projection  (far_projection),
		.channel         (channel),
		.event_valid     (event_valid),
		.event_ready     (event_ready),
		.event_code      (event_code),
		.too_high        (too_high),
		.channel_out     (channel_out)
	);

	bound_event_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.item_valid      (item_valid),
		.item_ready      (item_ready),
		.sample          (sample),
		.near_projection (near_projection),
		.far_projection  (far_projection),
		.channel         (channel),
		.event_valid     (event_valid),
		.event_ready     (event_ready),
		.event_code      (event_code),
		.too_high        (too_high),
		.channel_out     (channel_out),
		.mismatches      (mismatches),
		.pending         (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			event_ready <= 1'b0;
		end else if (stall_left == 0) begin
			stall_mode <= rx_mode_t'($urandom_range(0, 4));
			stall_left <= $urandom_range(8, 80);
			event_ready <= 1'b1;
		end else begin
			stall_left <= stall_left - 1;
			case (stall_mode)
				RX_OPEN:     event_ready <= 1'b1;
				RX_MOSTLY:   event_ready <= ($urandom_range(0, 3) != 0);
				RX_SPARSE:   event_ready <= ($urandom_range(0, 3) == 0);
				RX_PERIODIC: event_ready <= (stall_left[2:0] == 3'd0);
				default:     event_ready <= (stall_left < 50);
			endcase
		end
	end

	task automatic write_reg(input reg_index_t idx, input logic [DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic program_limits(
		input logic                     en,
		input logic signed [DATA_W-1:0] clo,
		input logic signed [DATA_W-1:0] chi,
		input logic [COUNT_W-1:0]       conf,
		input logic signed [DATA_W-1:0] wlo,
		input logic signed [DATA_W-1:0] whi
	);
		cur_clo = clo;
		cur_chi = chi;
		cur_conf = conf;
		cur_wlo = wlo;
		cur_whi = whi;
		write_reg(REG_CRITICAL_ENABLED, {31'b0, en});
		write_reg(REG_CRITICAL_LOW, clo);
		write_reg(REG_CRITICAL_HIGH, chi);
		write_reg(REG_CONFIRM_LIMIT, {24'b0, conf});
		write_reg(REG_WARNING_LOW, wlo);
		write_reg(REG_WARNING_HIGH, whi);
	endtask

	task automatic drain_pipeline();
		item_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_item(
		input logic signed [DATA_W-1:0] s,
		input logic signed [DATA_W-1:0] n,
		input logic signed [DATA_W-1:0] f,
		input logic [CHAN_W-1:0]        ch
	);
		if (burst_left == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(1, 20);
		end
		burst_left--;
		item_valid <= 1'b1;
		sample <= s;
		near_projection <= n;
		far_projection <= f;
		channel <= ch;
		do @(posedge clk); while (!item_ready);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_inside(
		input logic signed [DATA_W-1:0] lo,
		input logic signed [DATA_W-1:0] hi
	);
		longint span;
		longint r;
		span = longint'(hi) - longint'(lo);
		r = $urandom_range(0, 1023);
		if (span < 0)
			return $urandom;
		return DATA_W'(longint'(lo) + (span * r) / 1023);
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_near(
		input logic signed [DATA_W-1:0] lo,
		input logic signed [DATA_W-1:0] hi
	);
		case ($urandom_range(0, 9))
			0:       return lo;
			1:       return hi;
			2:       return lo - 1;
			3:       return hi + 1;
			4:       return S32_MIN;
			5:       return S32_MAX;
			6:       return $urandom;
			7:       return lo - $urandom_range(0, 50);
			8:       return hi + $urandom_range(0, 50);
			default: return pick_inside(lo, hi);
		endcase
	endfunction

	task automatic send_random();
		logic signed [DATA_W-1:0] s;
		logic signed [DATA_W-1:0] n;
		logic signed [DATA_W-1:0] f;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: s = pick_near(cur_wlo, cur_whi);
			5, 6, 7:       s = pick_near(cur_clo, cur_chi);
			default:       s = $urandom;
		endcase
		n = ($urandom_range(0, 3) == 0) ? pick_near(cur_clo, cur_chi)
		                                : pick_inside(cur_clo, cur_chi);
		f = ($urandom_range(0, 3) == 0) ? pick_near(cur_clo, cur_chi)
		                                : pick_inside(cur_clo, cur_chi);
		send_item(s, n, f, CHAN_W'($urandom));
	endtask

	task automatic apply_profile(input limit_profile_t p);
		int                       c;
		int                       w;
		logic signed [DATA_W-1:0] centre;
		case (p)
			PROF_DISABLED: begin
				c = $urandom_range(100, 1000);
				w = $urandom_range(10, 90);
				program_limits(1'b0, -c, c, COUNT_W'($urandom), -w, w);
			end
			PROF_NESTED: begin
				c = $urandom_range(1000, 100000);
				w = c / $urandom_range(2, 10);
				program_limits(1'b1, -c, c, COUNT_W'($urandom_range(1, 8)), -w, w);
			end
			PROF_SATURATE: begin
				w = $urandom_range(10, 1000);
				program_limits(1'b1, 0, -1, 8'd254, -w, w);
			end
			PROF_OPEN: begin
				w = $urandom_range(0, 1000);
				program_limits(1'b1, S32_MIN, S32_MAX, 8'd255, -w, S32_MAX);
			end
			PROF_POINT: begin
				centre = $urandom_range(0, 200) - 100;
				program_limits(1'b1, centre, centre, 8'd0,
					centre - $urandom_range(0, 20), centre + $urandom_range(0, 20));
			end
			default: begin
				program_limits(1'($urandom), $urandom, $urandom, COUNT_W'($urandom),
					$urandom, $urandom);
			end
		endcase
	endtask

	initial begin
		limit_profile_t profile;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(S32_MAX, S32_MIN, S32_MAX, 8'h00);
		send_item(S32_MIN, S32_MAX, S32_MIN, 8'hff);
		drain_pipeline();

		program_limits(1'b1, -1000, 1000, 8'd3, -100, 100);
		send_item(0, 0, 0, 8'h00);
		send_item(2000, 0, 0, 8'h01);
		send_item(-2000, 0, 0, 8'h02);
		send_item(0, 5000, 0, 8'h03);
		send_item(0, 0, -5000, 8'h04);
		send_item(500, 0, 0, 8'h05);
		send_item(600, 0, 0, 8'h06);
		send_item(0, 0, 0, 8'h07);
		send_item(-500, 0, 0, 8'hff);
		send_item(S32_MAX, S32_MIN, 0, 8'h55);
		send_item(0, S32_MIN, S32_MAX, 8'haa);
		send_item(0, 0, S32_MAX, 8'h0f);
		send_item(1000, -1000, 1000, 8'hf0);
		send_item(1001, 0, 0, 8'h10);
		send_item(-1001, 0, 0, 8'h20);
		send_item(100, -100, 0, 8'h30);
		send_item(101, 0, 0, 8'h40);
		send_item(-101, 0, 0, 8'h50);
		drain_pipeline();

		program_limits(1'b0, -1000, 1000, 8'd3, -100, 100);
		send_item(5000, S32_MIN, S32_MAX, 8'h60);
		send_item(0, 5000, -5000, 8'h70);
		send_item(5000, S32_MIN, S32_MAX, 8'h80);
		drain_pipeline();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0:       profile = PROF_NESTED;
				1:       profile = PROF_SATURATE;
				2:       profile = PROF_DISABLED;
				3:       profile = PROF_OPEN;
				4:       profile = PROF_POINT;
				5:       profile = PROF_WILD;
				default: profile = limit_profile_t'($urandom_range(0, 5));
			endcase
			apply_profile(profile);
			repeat ((profile == PROF_SATURATE) ? 300 : 140) send_random();
			drain_pipeline();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[critical_warning_bound_monitor_top.f]
rtl/core/cwbm_pkg.sv
rtl/core/cwbm_lane.sv
rtl/core/cwbm_cfg.sv
rtl/core/cwbm_merge.sv
rtl/core/critical_warning_bound_monitor_top.sv
verif/bound_event_checker.sv
verif/tb_critical_warning_bound_monitor_top.sv
